// ----- sv/ddsl_pkg.sv -----
package ddsl_pkg;

  // Default encoder count that corresponds to full wheel speed.
  localparam int unsigned FULL_SCALE_SPEED_DEF = 800;

  // Fixed-point one in Q14.
  localparam int unsigned ONE_Q14 = 16384;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PROPORTIONAL_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIVATIVE_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDFORWARD_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_RATIO        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_OFFSET       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_SPEED_LIMIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_SPEED_LIMIT   = 3'd6;

  typedef struct packed {
    logic signed [15:0] forward_cmd;
    logic signed [15:0] turn_cmd;
    logic               slow_mode;
    logic signed [15:0] right_speed_raw;
    logic signed [15:0] left_speed_raw;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left_drive;
    logic signed [15:0] right_drive;
    logic               stopped;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] proportional_gain;
    logic signed [15:0] derivative_gain;
    logic signed [15:0] feedforward_gain;
    logic signed [15:0] right_ratio;
    logic signed [15:0] right_offset;
    logic        [14:0] normal_speed_limit;
    logic        [14:0] slow_speed_limit;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    proportional_gain:  16'sd0,
    derivative_gain:    16'sd0,
    feedforward_gain:   16'sd16384,
    right_ratio:        16'sd16597,
    right_offset:       -16'sd213,
    normal_speed_limit: 15'd6554,
    slow_speed_limit:   15'd4915
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIX,
    ST_TGT,
    ST_ERR,
    ST_PMUL,
    ST_DMUL,
    ST_SUM,
    ST_CORR,
    ST_DONE
  } state_t;

  // Datapath operation for the current cycle.
  typedef enum logic [3:0] {
    STEP_NONE,
    STEP_DIV,
    STEP_FIX,
    STEP_TGT,
    STEP_ERR,
    STEP_PMUL,
    STEP_DMUL,
    STEP_SUM,
    STEP_CORR
  } step_t;

  typedef struct packed {
    logic  load_in;
    logic  load_out;
    step_t step;
  } dp_cmd_t;

  typedef struct packed {
    logic stop;
  } dp_status_t;

endpackage

// ----- sv/ddsl_cfg.sv -----
module ddsl_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [ddsl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ddsl_pkg::CFG_DATA_W-1:0]    cfg_data,
  output ddsl_pkg::cfg_t                     cfg
);
  import ddsl_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Writes to an index beyond the register list are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_PROPORTIONAL_GAIN:  cfg_nxt.proportional_gain  = signed'(cfg_data);
        CFG_DERIVATIVE_GAIN:    cfg_nxt.derivative_gain    = signed'(cfg_data);
        CFG_FEEDFORWARD_GAIN:   cfg_nxt.feedforward_gain   = signed'(cfg_data);
        CFG_RIGHT_RATIO:        cfg_nxt.right_ratio        = signed'(cfg_data);
        CFG_RIGHT_OFFSET:       cfg_nxt.right_offset       = signed'(cfg_data);
        CFG_NORMAL_SPEED_LIMIT: cfg_nxt.normal_speed_limit = cfg_data[14:0];
        CFG_SLOW_SPEED_LIMIT:   cfg_nxt.slow_speed_limit   = cfg_data[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- sv/ddsl_ctrl.sv -----
module ddsl_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ddsl_pkg::dp_cmd_t    cmd,
  input  ddsl_pkg::dp_status_t status
);
  import ddsl_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;
  logic   accept;

  // The result register can take a new item when empty or being drained.
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) || ((state_r == ST_DONE) && out_free);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_DIV;
      end
      ST_DIV:  state_nxt = status.stop ? ST_DONE : ST_FIX;
      ST_FIX:  state_nxt = ST_TGT;
      ST_TGT:  state_nxt = ST_ERR;
      ST_ERR:  state_nxt = ST_PMUL;
      ST_PMUL: state_nxt = ST_DMUL;
      ST_DMUL: state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_CORR;
      ST_CORR: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) state_nxt = accept ? ST_DIV : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.load_in  = accept;
    cmd.load_out = (state_r == ST_DONE) && out_free;
    unique case (state_r)
      ST_DIV:  cmd.step = STEP_DIV;
      ST_FIX:  cmd.step = STEP_FIX;
      ST_TGT:  cmd.step = STEP_TGT;
      ST_ERR:  cmd.step = STEP_ERR;
      ST_PMUL: cmd.step = STEP_PMUL;
      ST_DMUL: cmd.step = STEP_DMUL;
      ST_SUM:  cmd.step = STEP_SUM;
      ST_CORR: cmd.step = STEP_CORR;
      default: cmd.step = STEP_NONE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- sv/ddsl_datapath.sv -----
module ddsl_datapath #(
  parameter int unsigned FULL_SCALE_SPEED = ddsl_pkg::FULL_SCALE_SPEED_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ddsl_pkg::dp_cmd_t    cmd,
  output ddsl_pkg::dp_status_t status,
  input  ddsl_pkg::cfg_t       cfg,
  input  ddsl_pkg::in_item_t   in_data,
  output ddsl_pkg::out_item_t  out_data
);
  import ddsl_pkg::*;

  // Speed scaling is raw * 2^14 / FULL_SCALE_SPEED. The quotient estimate
  // uses floor(2^30 / FULL_SCALE_SPEED) and is low by at most one, which a
  // remainder check fixes.
  localparam logic [30:0] RECIP = 31'((64'd1 << 30) / FULL_SCALE_SPEED);
  localparam logic [14:0] FS    = 15'(FULL_SCALE_SPEED);
  localparam logic [14:0] LIM_MAX = 15'(ONE_Q14);

  function automatic logic signed [17:0] sat_err(input logic signed [31:0] v);
    if (v > 32'sd131071) begin
      return 18'sd131071;
    end else if (v < -32'sd131072) begin
      return -18'sd131072;
    end
    return v[17:0];
  endfunction

  function automatic logic signed [15:0] sat_drive(input logic signed [24:0] v);
    if (v > 25'sd16384) begin
      return 16'sd16384;
    end else if (v < -25'sd16384) begin
      return -16'sd16384;
    end
    return v[15:0];
  endfunction

  in_item_t item_r;

  // Shared multiplier lanes, one per wheel.
  logic signed [31:0] ra, la;
  logic signed [19:0] rb, lb;
  logic signed [51:0] rprod, lprod;
  logic signed [51:0] pr_r, pl_r;

  logic [29:0]        q0r_r, q0l_r;
  logic signed [31:0] measr_r, measl_r;
  logic signed [17:0] tgtr_r, tgtl_r;
  logic signed [17:0] errr_r, errl_r;
  logic signed [18:0] dr_r, dl_r;
  logic signed [34:0] paccr_r, paccl_r;
  logic signed [35:0] sumr_r, suml_r;

  // Loop state.
  logic signed [17:0] corr_r_r, corr_l_r;
  logic signed [17:0] prev_r_r, prev_l_r;

  out_item_t out_r;

  // Input-derived values.
  logic [14:0]        sel_lim, lim;
  logic [13:0]        half;
  logic signed [16:0] cmd_r, cmd_l;
  logic signed [16:0] rraw_x, lraw_x;
  logic [16:0]        r_mag, l_mag;
  logic signed [18:0] rt_off;

  // Measurement correction.
  logic [30:0]        r_num, l_num, r_rem, l_rem;
  logic [30:0]        r_q, l_q;
  logic signed [31:0] r_qs, l_qs, r_meas, l_meas;

  // Target and error.
  logic signed [31:0] r_tsum, l_tsum;
  logic signed [17:0] r_tgt, l_tgt;
  logic signed [31:0] r_diff, l_diff;

  // Correction update.
  logic signed [35:0] r_rs, l_rs;
  logic signed [23:0] r_cs, l_cs;
  logic signed [23:0] half_s;
  logic signed [17:0] r_corr_new, l_corr_new;

  // Drive outputs.
  logic signed [34:0] l_fs;
  logic signed [23:0] l_sum;
  logic signed [51:0] r_fs;
  logic signed [24:0] r_sum, l_neg;
  out_item_t          out_nxt;

  assign status.stop = (item_r.forward_cmd == 16'sd0) && (item_r.turn_cmd == 16'sd0);

  assign sel_lim = item_r.slow_mode ? cfg.slow_speed_limit : cfg.normal_speed_limit;
  assign lim     = (sel_lim > LIM_MAX) ? LIM_MAX : sel_lim;
  assign half    = lim[14:1];

  // The turn command is negated, so the right wheel sees forward + turn.
  assign cmd_r = {item_r.forward_cmd[15], item_r.forward_cmd}
               + {item_r.turn_cmd[15], item_r.turn_cmd};
  assign cmd_l = {item_r.forward_cmd[15], item_r.forward_cmd}
               - {item_r.turn_cmd[15], item_r.turn_cmd};

  assign rraw_x = {item_r.right_speed_raw[15], item_r.right_speed_raw};
  assign lraw_x = {item_r.left_speed_raw[15], item_r.left_speed_raw};
  assign r_mag  = item_r.right_speed_raw[15] ? 17'(-rraw_x) : 17'(rraw_x);
  assign l_mag  = item_r.left_speed_raw[15] ? 17'(-lraw_x) : 17'(lraw_x);

  assign rt_off = {tgtr_r[17], tgtr_r} + {{3{cfg.right_offset[15]}}, cfg.right_offset};

  always_comb begin
    ra = '0;
    rb = '0;
    la = '0;
    lb = '0;
    unique case (cmd.step)
      STEP_DIV: begin
        ra = {1'b0, RECIP};
        rb = {3'b0, r_mag};
        la = {1'b0, RECIP};
        lb = {3'b0, l_mag};
      end
      STEP_FIX: begin
        ra = {2'b0, pr_r[45:16]};
        rb = {5'b0, FS};
        la = {2'b0, pl_r[45:16]};
        lb = {5'b0, FS};
      end
      STEP_TGT: begin
        ra = {{15{cmd_r[16]}}, cmd_r};
        rb = {5'b0, lim};
        la = {{15{cmd_l[16]}}, cmd_l};
        lb = {5'b0, lim};
      end
      STEP_PMUL: begin
        ra = {{14{errr_r[17]}}, errr_r};
        rb = {{4{cfg.proportional_gain[15]}}, cfg.proportional_gain};
        la = {{14{errl_r[17]}}, errl_r};
        lb = {{4{cfg.proportional_gain[15]}}, cfg.proportional_gain};
      end
      STEP_DMUL: begin
        ra = {{13{dr_r[18]}}, dr_r};
        rb = {{4{cfg.derivative_gain[15]}}, cfg.derivative_gain};
        la = {{13{dl_r[18]}}, dl_r};
        lb = {{4{cfg.derivative_gain[15]}}, cfg.derivative_gain};
      end
      STEP_SUM: begin
        ra = {{16{cfg.feedforward_gain[15]}}, cfg.feedforward_gain};
        rb = {{4{cfg.right_ratio[15]}}, cfg.right_ratio};
        la = {{14{tgtl_r[17]}}, tgtl_r};
        lb = {{4{cfg.feedforward_gain[15]}}, cfg.feedforward_gain};
      end
      STEP_CORR: begin
        ra = pr_r[31:0];
        rb = {rt_off[18], rt_off};
      end
      default: ;
    endcase
  end

  assign rprod = ra * rb;
  assign lprod = la * lb;

  // Truncated quotient: bump the estimate when the remainder reaches the divisor.
  assign r_num  = {r_mag, 14'b0};
  assign l_num  = {l_mag, 14'b0};
  assign r_rem  = r_num - pr_r[30:0];
  assign l_rem  = l_num - pl_r[30:0];
  assign r_q    = {1'b0, q0r_r} + ((r_rem >= {16'b0, FS}) ? 31'd1 : 31'd0);
  assign l_q    = {1'b0, q0l_r} + ((l_rem >= {16'b0, FS}) ? 31'd1 : 31'd0);
  assign r_qs   = {1'b0, r_q};
  assign l_qs   = {1'b0, l_q};
  assign r_meas = item_r.right_speed_raw[15] ? -r_qs : r_qs;
  // The left encoder counts backward.
  assign l_meas = item_r.left_speed_raw[15] ? l_qs : -l_qs;

  assign r_tsum = pr_r[31:0] + 32'sd8192;
  assign l_tsum = pl_r[31:0] + 32'sd8192;
  assign r_tgt  = r_tsum[31:14];
  assign l_tgt  = l_tsum[31:14];
  assign r_diff = {{14{r_tgt[17]}}, r_tgt} - measr_r;
  assign l_diff = {{14{l_tgt[17]}}, l_tgt} - measl_r;

  assign r_rs   = sumr_r + 36'sd8192;
  assign l_rs   = suml_r + 36'sd8192;
  assign r_cs   = {{6{corr_r_r[17]}}, corr_r_r} + {{2{r_rs[35]}}, r_rs[35:14]};
  assign l_cs   = {{6{corr_l_r[17]}}, corr_l_r} + {{2{l_rs[35]}}, l_rs[35:14]};
  assign half_s = {10'b0, half};

  always_comb begin
    if (r_cs > half_s) begin
      r_corr_new = half_s[17:0];
    end else if (r_cs < -half_s) begin
      r_corr_new = 18'(-half_s);
    end else begin
      r_corr_new = r_cs[17:0];
    end
    if (l_cs > half_s) begin
      l_corr_new = half_s[17:0];
    end else if (l_cs < -half_s) begin
      l_corr_new = 18'(-half_s);
    end else begin
      l_corr_new = l_cs[17:0];
    end
  end

  assign l_fs  = pl_r[34:0] + 35'sd8192;
  assign l_sum = {{6{corr_l_r[17]}}, corr_l_r} + {{3{l_fs[34]}}, l_fs[34:14]};
  assign l_neg = -{l_sum[23], l_sum};
  assign r_fs  = pr_r + 52'sd134217728;
  assign r_sum = {{7{corr_r_r[17]}}, corr_r_r} + {r_fs[51], r_fs[51:28]};

  always_comb begin
    if (status.stop) begin
      out_nxt.left_drive  = 16'sd0;
      out_nxt.right_drive = 16'sd0;
      out_nxt.stopped     = 1'b1;
    end else begin
      out_nxt.left_drive  = sat_drive(l_neg);
      out_nxt.right_drive = sat_drive(r_sum);
      out_nxt.stopped     = 1'b0;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      item_r <= in_data;
    end
    if (cmd.load_out) begin
      out_r <= out_nxt;
    end
    unique case (cmd.step)
      STEP_DIV: begin
        pr_r <= rprod;
        pl_r <= lprod;
      end
      STEP_FIX: begin
        q0r_r <= pr_r[45:16];
        q0l_r <= pl_r[45:16];
        pr_r  <= rprod;
        pl_r  <= lprod;
      end
      STEP_TGT: begin
        measr_r <= r_meas;
        measl_r <= l_meas;
        pr_r    <= rprod;
        pl_r    <= lprod;
      end
      STEP_ERR: begin
        tgtr_r <= r_tgt;
        tgtl_r <= l_tgt;
        errr_r <= sat_err(r_diff);
        errl_r <= sat_err(l_diff);
      end
      STEP_PMUL: begin
        dr_r <= {errr_r[17], errr_r} - {prev_r_r[17], prev_r_r};
        dl_r <= {errl_r[17], errl_r} - {prev_l_r[17], prev_l_r};
        pr_r <= rprod;
        pl_r <= lprod;
      end
      STEP_DMUL: begin
        paccr_r <= pr_r[34:0];
        paccl_r <= pl_r[34:0];
        pr_r    <= rprod;
        pl_r    <= lprod;
      end
      STEP_SUM: begin
        sumr_r <= {paccr_r[34], paccr_r} + {pr_r[34], pr_r[34:0]};
        suml_r <= {paccl_r[34], paccl_r} + {pl_r[34], pl_r[34:0]};
        pr_r   <= rprod;
        pl_r   <= lprod;
      end
      STEP_CORR: begin
        pr_r <= rprod;
      end
      default: ;
    endcase
  end

  // Loop state: errors and corrections carried from tick to tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corr_r_r <= '0;
      corr_l_r <= '0;
      prev_r_r <= '0;
      prev_l_r <= '0;
    end else if (cmd.load_out && status.stop) begin
      corr_r_r <= '0;
      corr_l_r <= '0;
      prev_r_r <= '0;
      prev_l_r <= '0;
    end else if (cmd.step == STEP_PMUL) begin
      prev_r_r <= errr_r;
      prev_l_r <= errl_r;
    end else if (cmd.step == STEP_CORR) begin
      corr_r_r <= r_corr_new;
      corr_l_r <= l_corr_new;
    end
  end

  assign out_data = out_r;

endmodule

// ----- sv/differential_drive_speed_loop_top.sv -----
// Differential-drive wheel speed loop with incremental PD correction and
// feedforward. Each item on the input channel is one control tick: forward
// and turn commands, a slow-mode flag and the raw right and left encoder
// speeds. Each tick produces exactly one item on the output channel with the
// saturated left and right drive values and a stopped flag.
// Both channels use valid/ready; an item moves when valid and ready are high
// at a rising clock edge. The configuration port writes one gain or limit
// register per cycle with cfg_we high; it is meant to be written while idle.
// A normal tick passes through every step before its result is loaded; a
// tick with both commands zero goes from the scaling step to loading. Each
// wheel has one multiplier, and the products go through it in sequence (speed
// scaling and its correction, targets, P and D terms, feedforward).
// The next item is accepted in the same cycle the current result is loaded.
// A result waits in the output register while out_ready is low, and the next
// item still enters; it then holds in its last step until the register frees.
// The synchronous active-low reset clears the loop state (corrections and
// previous errors), loads the register defaults and empties the output.
module differential_drive_speed_loop_top #(
  parameter int unsigned FULL_SCALE_SPEED = ddsl_pkg::FULL_SCALE_SPEED_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ddsl_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ddsl_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [ddsl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ddsl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ddsl_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  // Gain and limit registers.
  ddsl_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Sequencer: walks each item through the datapath steps and owns the
  // channel handshakes.
  ddsl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // Arithmetic, loop state and the output register.
  ddsl_datapath #(
    .FULL_SCALE_SPEED (FULL_SCALE_SPEED)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .status   (status),
    .cfg      (cfg),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

// ----- tb/sv/differential_drive_speed_loop_top_tb.sv -----
module differential_drive_speed_loop_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  // Encoder count that the block maps to full wheel speed, and Q14 one, kept
  // as signed 64-bit values so that none of the loop arithmetic goes unsigned.
  localparam longint FULL_SCALE = longint'(ddsl_pkg::FULL_SCALE_SPEED_DEF);
  localparam longint Q14_ONE = 64'sd16384;
  localparam longint ERR_HI = 64'sd131071;
  localparam longint ERR_LO = -64'sd131072;

  // Cycles with no item moving on either channel before the run is called hung.
  // A correct run never comes near this, not even with idle gaps on both sides
  // or a register setting under way.
  localparam int HANG_LIMIT = 2000;
  localparam int NUM_PHASES = 9;

  // Keeps its own copy of the gain and limit registers and of the loop state
  // (corrections and previous errors), works out the drive values for every
  // tick the block accepts, and compares the block's results against them.
  class speed_loop_scoreboard;
    ddsl_pkg::cfg_t regs;
    longint right_corr;
    longint left_corr;
    longint right_prev_err;
    longint left_prev_err;
    ddsl_pkg::out_item_t drive_expected[$];
    int mismatches;

    function new();
      regs = ddsl_pkg::CFG_RESET;
      clear_loop();
      mismatches = 0;
    endfunction

    function void clear_loop();
      right_corr = 0;
      left_corr = 0;
      right_prev_err = 0;
      left_prev_err = 0;
    endfunction

    // Round half up: floor((v + 2^(n-1)) / 2^n).
    function longint round_q(longint v, int n);
      return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function longint sat(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(logic [ddsl_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
      case (idx)
        ddsl_pkg::CFG_PROPORTIONAL_GAIN:  regs.proportional_gain = val;
        ddsl_pkg::CFG_DERIVATIVE_GAIN:    regs.derivative_gain = val;
        ddsl_pkg::CFG_FEEDFORWARD_GAIN:   regs.feedforward_gain = val;
        ddsl_pkg::CFG_RIGHT_RATIO:        regs.right_ratio = val;
        ddsl_pkg::CFG_RIGHT_OFFSET:       regs.right_offset = val;
        ddsl_pkg::CFG_NORMAL_SPEED_LIMIT: regs.normal_speed_limit = val[14:0];
        ddsl_pkg::CFG_SLOW_SPEED_LIMIT:   regs.slow_speed_limit = val[14:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return drive_expected.size();
    endfunction

    // Advances the loop by one tick and queues the drive values it produces.
    function void note_tick(ddsl_pkg::in_item_t t);
      longint fwd, trn, r_meas, l_meas, lim, half;
      longint r_tgt, l_tgt, r_err, l_err, r_d, l_d, l_drv, r_drv;
      longint pg, dg, ffg, ratio, offs;
      ddsl_pkg::out_item_t res;
      fwd = longint'($signed(t.forward_cmd));
      trn = -longint'($signed(t.turn_cmd));
      r_meas = (longint'($signed(t.right_speed_raw)) * Q14_ONE) / FULL_SCALE;
      l_meas = -((longint'($signed(t.left_speed_raw)) * Q14_ONE) / FULL_SCALE);
      res.stopped = 1'b0;
      if (fwd == 0 && trn == 0) begin
        clear_loop();
        res.left_drive = '0;
        res.right_drive = '0;
        res.stopped = 1'b1;
        drive_expected.push_back(res);
        return;
      end
      pg = longint'($signed(regs.proportional_gain));
      dg = longint'($signed(regs.derivative_gain));
      ffg = longint'($signed(regs.feedforward_gain));
      ratio = longint'($signed(regs.right_ratio));
      offs = longint'($signed(regs.right_offset));
      lim = t.slow_mode ? longint'(regs.slow_speed_limit) : longint'(regs.normal_speed_limit);
      if (lim > Q14_ONE) lim = Q14_ONE;
      half = lim >>> 1;
      r_tgt = round_q(lim * (fwd - trn), 14);
      l_tgt = round_q(lim * (fwd + trn), 14);
      r_err = sat(r_tgt - r_meas, ERR_LO, ERR_HI);
      l_err = sat(l_tgt - l_meas, ERR_LO, ERR_HI);
      r_d = r_err - right_prev_err;
      l_d = l_err - left_prev_err;
      right_prev_err = r_err;
      left_prev_err = l_err;
      right_corr = sat(right_corr + round_q(pg * r_err + dg * r_d, 14), -half, half);
      left_corr = sat(left_corr + round_q(pg * l_err + dg * l_d, 14), -half, half);
      l_drv = -(left_corr + round_q(ffg * l_tgt, 14));
      r_drv = right_corr + round_q(ffg * ratio * (r_tgt + offs), 28);
      l_drv = sat(l_drv, -Q14_ONE, Q14_ONE);
      r_drv = sat(r_drv, -Q14_ONE, Q14_ONE);
      res.left_drive = l_drv[15:0];
      res.right_drive = r_drv[15:0];
      drive_expected.push_back(res);
    endfunction

    function void check_drive(ddsl_pkg::out_item_t got);
      ddsl_pkg::out_item_t want;
      if (drive_expected.size() == 0) begin
        mismatches++;
        $display("%0t: result with no tick pending, actual left %0d right %0d stopped %0b",
                 $time, $signed(got.left_drive), $signed(got.right_drive), got.stopped);
        return;
      end
      want = drive_expected.pop_front();
      if (got.left_drive !== want.left_drive || got.right_drive !== want.right_drive ||
          got.stopped !== want.stopped) begin
        mismatches++;
        $display("%0t: expected %0d/%0d/%0b, actual %0d/%0d/%0b (left/right/stopped)",
                 $time, $signed(want.left_drive), $signed(want.right_drive), want.stopped,
                 $signed(got.left_drive), $signed(got.right_drive), got.stopped);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  ddsl_pkg::in_item_t in_data;
  logic out_valid;
  logic out_ready;
  ddsl_pkg::out_item_t out_data;
  logic cfg_we;
  logic [ddsl_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ddsl_pkg::CFG_DATA_W-1:0] cfg_data;

  speed_loop_scoreboard sb = new();

  // When clear, both sides run flat out for the whole phase, so that ticks
  // arrive back to back and results are taken the cycle they appear.
  bit idle_on;
  int idle_cycles;

  differential_drive_speed_loop_top DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Every flop in the block and every drive from this bench changes in the
  // nonblocking region, so values read right after a rising edge are the ones
  // the edge itself saw.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= HANG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic ddsl_pkg::in_item_t tick(int fwd, int turn, bit slow, int rs, int ls);
    ddsl_pkg::in_item_t t;
    t.forward_cmd = 16'(fwd);
    t.turn_cmd = 16'(turn);
    t.slow_mode = slow;
    t.right_speed_raw = 16'(rs);
    t.left_speed_raw = 16'(ls);
    return t;
  endfunction

  // Most ticks are what a driver would send: commands within plus or minus
  // one and wheel speeds near the range the targets ask for, so that the
  // corrections build up over runs of ticks. A few are stop ticks that clear
  // the loop, a few have only one command at zero, and the rest are noise
  // across the whole width of every field.
  function automatic ddsl_pkg::in_item_t random_tick();
    ddsl_pkg::in_item_t t;
    int pick;
    int fwd, turn;
    pick = $urandom_range(0, 99);
    t.slow_mode = 1'($urandom_range(0, 1));
    t.right_speed_raw = 16'($urandom);
    t.left_speed_raw = 16'($urandom);
    if (pick < 8) begin
      t.forward_cmd = '0;
      t.turn_cmd = '0;
    end else if (pick < 20) begin
      t.forward_cmd = 16'($urandom);
      t.turn_cmd = 16'($urandom);
    end else begin
      fwd = int'($urandom_range(0, 32768)) - 16384;
      turn = int'($urandom_range(0, 32768)) - 16384;
      if (pick < 26) fwd = 0;
      else if (pick < 32) turn = 0;
      t.forward_cmd = 16'(fwd);
      t.turn_cmd = 16'(turn);
      t.right_speed_raw = 16'(int'($urandom_range(0, 2000)) - 1000);
      t.left_speed_raw = 16'(int'($urandom_range(0, 2000)) - 1000);
    end
    return t;
  endfunction

  // Offers one tick and returns at the edge where the block takes it. Valid
  // is dropped only when an idle gap comes before this tick, so a tick that
  // follows straight on keeps valid high with no second assignment.
  task automatic push_tick(input ddsl_pkg::in_item_t t);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (!in_ready);
    sb.note_tick(t);
  endtask

  // Holds off the sender until every queued result has been taken, so the
  // block is idle before any register changes.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ddsl_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic write_all(input logic [15:0] p, input logic [15:0] d, input logic [15:0] ff,
                           input logic [15:0] ratio, input logic [15:0] offs,
                           input logic [15:0] norm_lim, input logic [15:0] slow_lim);
    write_reg(ddsl_pkg::CFG_PROPORTIONAL_GAIN, p);
    write_reg(ddsl_pkg::CFG_DERIVATIVE_GAIN, d);
    write_reg(ddsl_pkg::CFG_FEEDFORWARD_GAIN, ff);
    write_reg(ddsl_pkg::CFG_RIGHT_RATIO, ratio);
    write_reg(ddsl_pkg::CFG_RIGHT_OFFSET, offs);
    write_reg(ddsl_pkg::CFG_NORMAL_SPEED_LIMIT, norm_lim);
    write_reg(ddsl_pkg::CFG_SLOW_SPEED_LIMIT, slow_lim);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] random_limit();
    // Mostly a legal limit; now and then any 16-bit value, whose top bit the
    // block must drop and which it must saturate to one if still above one.
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 16384));
  endfunction

  // Phase one carries a plausible tuning, phase two every register at its
  // positive extreme with limits above one, phase three every register at its
  // negative extreme with both limits at zero, phase four limits at exactly
  // one with strong gains of opposite sign, and the rest draw everything.
  task automatic apply_setting(input int phase);
    case (phase)
      1: write_all(16'd4000, 16'd1500, 16'd16384, 16'd16597, 16'(-213), 16'd6554, 16'd4915);
      2: write_all(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      3: write_all(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
      4: write_all(16'd16384, 16'(-8000), 16'd12000, 16'd16384, 16'd0, 16'd16384, 16'd16384);
      default: write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), random_limit(), random_limit());
    endcase
  endtask

  // Hand-picked ticks under the plausible tuning: stops with and without
  // speeds, each command alone at both ends, both commands together, commands
  // and speeds at the ends of their full widths so the errors saturate, the
  // smallest nonzero commands, and a steady command held long enough for the
  // corrections to run into their clamp.
  task automatic directed_ticks();
    push_tick(tick(0, 0, 1'b0, 0, 0));
    push_tick(tick(16384, 0, 1'b0, 0, 0));
    push_tick(tick(16384, 0, 1'b0, 300, -300));
    push_tick(tick(-16384, 0, 1'b0, -300, 300));
    push_tick(tick(0, 16384, 1'b0, 100, 100));
    push_tick(tick(0, -16384, 1'b0, -100, -100));
    push_tick(tick(16384, 16384, 1'b1, 0, 0));
    push_tick(tick(-16384, -16384, 1'b1, 0, 0));
    push_tick(tick(32767, -32768, 1'b0, 32767, -32768));
    push_tick(tick(-32768, 32767, 1'b1, -32768, 32767));
    push_tick(tick(0, 0, 1'b1, 32767, -32768));
    push_tick(tick(1, 0, 1'b0, 0, 0));
    push_tick(tick(0, -1, 1'b1, 0, 0));
    repeat (6) push_tick(tick(8000, 3000, 1'b0, 0, 0));
    push_tick(tick(0, 0, 1'b0, 0, 0));
  endtask

  // The result side: takes one result per draw, after a random idle gap when
  // idle gaps are on, and hands each one to the scoreboard.
  initial begin : result_side
    int gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = idle_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_drive(out_data);
    end
  end

  initial begin : tick_side
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_on = 1'b1;
    idle_cycles = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Phase zero runs on the register defaults from reset; every later phase
    // starts from an idle block with a fresh setting of all seven registers.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) apply_setting(ph);
      idle_on = (ph % 3) != 2;
      if (ph == 1) directed_ticks();
      repeat ((ph == 0) ? 60 : 190) push_tick(random_tick());
      settle();
    end

    // Any stray result would arrive within a tick's latency.
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
